/* sv/epcal_pkg.sv */
// Package for the epoch-seconds to calendar converter.
// Holds the sequencer states, the calendar result type, constants and the month-length table.
// No dependencies.
`default_nettype none

package epcal_pkg;

  // Widths of the working datapath.
  localparam int AccW  = 33;  // clamped adjusted seconds, below 2^33
  localparam int DivW  = 17;  // widest divisor or subtrahend (86400)
  localparam int ShW   = 4;   // shift count of the divide steps
  localparam int DaysW = 16;  // whole days since the epoch

  // Arithmetic constants.
  localparam logic [DivW-1:0] SecsPerDay  = 17'd86400;
  localparam logic [DivW-1:0] SecsPerHour = 17'd3600;
  localparam logic [DivW-1:0] SecsPerMin  = 17'd60;
  localparam logic [DivW-1:0] DaysPerWeek = 17'd7;
  localparam logic [DivW-1:0] DaysPerYear = 17'd365;
  localparam logic [11:0]     BaseYear    = 12'd1970;
  localparam logic [2:0]      BaseWeekday = 3'd4;     // 1970-01-01 was a Thursday

  // Starting shift count of each long division, set by its largest quotient.
  localparam logic [ShW-1:0] DayShTop  = 4'd15;
  localparam logic [ShW-1:0] HourShTop = 4'd4;
  localparam logic [ShW-1:0] MinShTop  = 4'd5;
  localparam logic [ShW-1:0] WdayShTop = 4'd12;

  // Position of the base year in the leap cycles.
  localparam logic [1:0] BaseMod4   = 2'd2;
  localparam logic [6:0] BaseMod100 = 7'd70;
  localparam logic [8:0] BaseMod400 = 9'd370;
  localparam logic [6:0] LastMod100 = 7'd99;
  localparam logic [8:0] LastMod400 = 9'd399;

  localparam logic [3:0] LastMonth = 4'd11;  // December, zero based
  localparam logic [3:0] Feb       = 4'd1;

  // Configuration register indexes.
  localparam logic CfgZoneOffset = 1'b0;
  localparam logic CfgDaylight   = 1'b1;

  localparam logic [15:0] DstSecs = 16'd3600;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_WDAY,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
  } cal_t;

  // Days in a month, zero-based month index.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    begin
      unique case (mon)
        4'd1:                      len = leap ? 5'd29 : 5'd28;
        4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
        default:                   len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

/* sv/epcal_cmp_sub.sv */
// Shared compare-and-subtract unit of the calendar converter.
// Shifts the subtrahend left, compares and gives the difference. Uses epcal_pkg.
`default_nettype none

module epcal_cmp_sub (
  input  wire logic [epcal_pkg::AccW-1:0] a_i,
  input  wire logic [epcal_pkg::DivW-1:0] b_i,
  input  wire logic [epcal_pkg::ShW-1:0]  sh_i,
  output      logic [epcal_pkg::AccW-1:0] diff_o,
  output      logic                       ge_o
);

  logic [epcal_pkg::AccW-1:0] b_sh;

  assign b_sh   = {{(epcal_pkg::AccW-epcal_pkg::DivW){1'b0}}, b_i} << sh_i;
  assign ge_o   = (a_i >= b_sh);
  assign diff_o = a_i - b_sh;

endmodule

`default_nettype wire

/* sv/epcal_seq.sv */
// Sequencer and working registers of the calendar converter.
// Drives the shared epcal_cmp_sub unit through divisions, year and month steps. Uses epcal_pkg.
`default_nettype none

module epcal_seq (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start_i,
  input  wire logic [epcal_pkg::AccW-1:0] adj_i,
  input  wire logic                       take_i,
  output      logic                       idle_o,
  output      logic                       done_o,
  output      epcal_pkg::cal_t            res_o
);

  epcal_pkg::state_t state_r, state_nxt;

  logic [epcal_pkg::AccW-1:0]  acc_r, acc_nxt;
  logic [epcal_pkg::DaysW-1:0] q_r, q_nxt;
  logic [epcal_pkg::ShW-1:0]   k_r, k_nxt;
  logic [epcal_pkg::DaysW-1:0] days_r, days_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic [11:0] year_r, year_nxt;
  logic [1:0]  m4_r, m4_nxt;
  logic [6:0]  m100_r, m100_nxt;
  logic [8:0]  m400_r, m400_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [8:0]  yday_r, yday_nxt;

  logic [epcal_pkg::DivW-1:0]  op_b;
  logic [epcal_pkg::ShW-1:0]   op_sh;
  logic [epcal_pkg::AccW-1:0]  diff;
  logic                        ge;
  logic [epcal_pkg::AccW-1:0]  acc_step;
  logic [epcal_pkg::DaysW-1:0] q_shift;
  logic                        last;
  logic                        leap;
  logic                        mon_go;

  epcal_cmp_sub u_cmp_sub (
    .a_i    (acc_r),
    .b_i    (op_b),
    .sh_i   (op_sh),
    .diff_o (diff),
    .ge_o   (ge)
  );

  assign leap     = ((m4_r == 2'd0) && (m100_r != 7'd0)) || (m400_r == 9'd0);
  assign acc_step = ge ? diff : acc_r;
  assign q_shift  = {q_r[epcal_pkg::DaysW-2:0], ge};
  assign last     = (k_r == '0);
  assign mon_go   = (mon_r < epcal_pkg::LastMonth) && ge;

  // Operand selection for the shared unit.
  always_comb begin
    op_b  = '0;
    op_sh = k_r;
    unique case (state_r)
      epcal_pkg::ST_DAY:   op_b = epcal_pkg::SecsPerDay;
      epcal_pkg::ST_HOUR:  op_b = epcal_pkg::SecsPerHour;
      epcal_pkg::ST_MIN:   op_b = epcal_pkg::SecsPerMin;
      epcal_pkg::ST_WDAY:  op_b = epcal_pkg::DaysPerWeek;
      epcal_pkg::ST_YEAR: begin
        op_b  = epcal_pkg::DaysPerYear + {{(epcal_pkg::DivW-1){1'b0}}, leap};
        op_sh = '0;
      end
      epcal_pkg::ST_MONTH: begin
        op_b  = {{(epcal_pkg::DivW-5){1'b0}}, epcal_pkg::month_len(mon_r, leap)};
        op_sh = '0;
      end
      default: begin
        op_b  = '0;
        op_sh = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      epcal_pkg::ST_IDLE:  if (start_i) state_nxt = epcal_pkg::ST_DAY;
      epcal_pkg::ST_DAY:   if (last) state_nxt = epcal_pkg::ST_HOUR;
      epcal_pkg::ST_HOUR:  if (last) state_nxt = epcal_pkg::ST_MIN;
      epcal_pkg::ST_MIN:   if (last) state_nxt = epcal_pkg::ST_WDAY;
      epcal_pkg::ST_WDAY:  if (last) state_nxt = epcal_pkg::ST_YEAR;
      epcal_pkg::ST_YEAR:  if (!ge) state_nxt = epcal_pkg::ST_MONTH;
      epcal_pkg::ST_MONTH: if (!mon_go) state_nxt = epcal_pkg::ST_DONE;
      epcal_pkg::ST_DONE:  if (take_i) state_nxt = epcal_pkg::ST_IDLE;
      default:             state_nxt = epcal_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    k_nxt    = k_r;
    days_nxt = days_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    wday_nxt = wday_r;
    year_nxt = year_r;
    m4_nxt   = m4_r;
    m100_nxt = m100_r;
    m400_nxt = m400_r;
    mon_nxt  = mon_r;
    yday_nxt = yday_r;
    unique case (state_r)
      epcal_pkg::ST_IDLE: begin
        if (start_i) begin
          acc_nxt = adj_i;
          q_nxt   = '0;
          k_nxt   = epcal_pkg::DayShTop;
        end
      end
      epcal_pkg::ST_DAY: begin
        acc_nxt = acc_step;
        q_nxt   = q_shift;
        k_nxt   = k_r - 1'b1;
        if (last) begin
          days_nxt = q_shift;
          q_nxt    = '0;
          k_nxt    = epcal_pkg::HourShTop;
        end
      end
      epcal_pkg::ST_HOUR: begin
        acc_nxt = acc_step;
        q_nxt   = q_shift;
        k_nxt   = k_r - 1'b1;
        if (last) begin
          hour_nxt = q_shift[4:0];
          q_nxt    = '0;
          k_nxt    = epcal_pkg::MinShTop;
        end
      end
      epcal_pkg::ST_MIN: begin
        acc_nxt = acc_step;
        q_nxt   = q_shift;
        k_nxt   = k_r - 1'b1;
        if (last) begin
          min_nxt = q_shift[5:0];
          sec_nxt = acc_step[5:0];
          acc_nxt = {{(epcal_pkg::AccW-epcal_pkg::DaysW){1'b0}}, days_r}
                    + {{(epcal_pkg::AccW-3){1'b0}}, epcal_pkg::BaseWeekday};
          q_nxt   = '0;
          k_nxt   = epcal_pkg::WdayShTop;
        end
      end
      epcal_pkg::ST_WDAY: begin
        acc_nxt = acc_step;
        k_nxt   = k_r - 1'b1;
        if (last) begin
          wday_nxt = acc_step[2:0];
          acc_nxt  = {{(epcal_pkg::AccW-epcal_pkg::DaysW){1'b0}}, days_r};
          year_nxt = epcal_pkg::BaseYear;
          m4_nxt   = epcal_pkg::BaseMod4;
          m100_nxt = epcal_pkg::BaseMod100;
          m400_nxt = epcal_pkg::BaseMod400;
        end
      end
      epcal_pkg::ST_YEAR: begin
        if (ge) begin
          acc_nxt  = diff;
          year_nxt = year_r + 1'b1;
          m4_nxt   = m4_r + 1'b1;
          m100_nxt = (m100_r == epcal_pkg::LastMod100) ? 7'd0 : m100_r + 1'b1;
          m400_nxt = (m400_r == epcal_pkg::LastMod400) ? 9'd0 : m400_r + 1'b1;
        end else begin
          yday_nxt = acc_r[8:0];
          mon_nxt  = '0;
        end
      end
      epcal_pkg::ST_MONTH: begin
        if (mon_go) begin
          acc_nxt = diff;
          mon_nxt = mon_r + 1'b1;
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= epcal_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    k_r    <= k_nxt;
    days_r <= days_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    sec_r  <= sec_nxt;
    wday_r <= wday_nxt;
    year_r <= year_nxt;
    m4_r   <= m4_nxt;
    m100_r <= m100_nxt;
    m400_r <= m400_nxt;
    mon_r  <= mon_nxt;
    yday_r <= yday_nxt;
  end

  assign idle_o = (state_r == epcal_pkg::ST_IDLE);
  assign done_o = (state_r == epcal_pkg::ST_DONE);

  always_comb begin
    res_o.year         = year_r;
    res_o.month        = mon_r + 1'b1;
    res_o.day_of_month = acc_r[4:0] + 1'b1;
    res_o.hour         = hour_r;
    res_o.minute       = min_r;
    res_o.second       = sec_r;
    res_o.weekday      = wday_r;
    res_o.day_of_year  = yday_r;
  end

`ifndef SYNTHESIS
  // The month walk never passes December.
  a_month_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == epcal_pkg::ST_MONTH) |-> (mon_r <= epcal_pkg::LastMonth))
    else $error("month index past December");

  // Seconds of day are reduced below one day once the day division ends.
  a_sod_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == epcal_pkg::ST_HOUR) && $past(state_r == epcal_pkg::ST_DAY)
    |-> (acc_r < {{(epcal_pkg::AccW-epcal_pkg::DivW){1'b0}}, epcal_pkg::SecsPerDay}))
    else $error("seconds of day not reduced");

  // The year walk stays inside the representable range.
  a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == epcal_pkg::ST_YEAR) |-> (year_r <= 12'd2106))
    else $error("year walk overran");

  // A finished result has a valid time of day and weekday.
  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == epcal_pkg::ST_DONE)
    |-> (hour_r <= 5'd23) && (min_r <= 6'd59) && (sec_r <= 6'd59) && (wday_r <= 3'd6))
    else $error("time fields out of range");
`endif

endmodule

`default_nettype wire

/* sv/epoch_seconds_to_calendar.sv */
// Top level of the epoch-seconds to local calendar converter.
// Holds the configuration registers, the offset adjustment and the result register.
// Uses epcal_pkg and epcal_seq (which uses epcal_cmp_sub).
//
//   Channel  Ports                           Moves
//   -------  ------------------------------  ----------------------------------------
//   in       in_valid / in_ready             one item: epoch_seconds
//   out      out_valid / out_ready           one item: calendar fields and flags
//   cfg      cfg_we, cfg_index, cfg_wdata    register writes, no wait, no read-back
//
// An item's result shows on the output once the sequencer has walked all of its steps on the
// single compare-and-subtract unit: 16 + 5 + 6 + 13 long-division steps, one step per
// elapsed year plus a closing compare (up to 137), the same for the months (up to 12), and
// the done state that hands the result over.
// The block takes a new item once the sequencer is idle, even while the last result still
// waits in the output register; a result that finds that register full holds the sequencer
// in its done state. Reset is synchronous and active low; it clears the configuration
// registers to zero and empties the sequencer and the output register.
`default_nettype none

module epoch_seconds_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [31:0] in_epoch_seconds,

  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [11:0] out_year,
  output      logic [3:0]  out_month,
  output      logic [4:0]  out_day_of_month,
  output      logic [4:0]  out_hour,
  output      logic [5:0]  out_minute,
  output      logic [5:0]  out_second,
  output      logic [2:0]  out_weekday,
  output      logic [8:0]  out_day_of_year,
  output      logic        out_daylight_flag,
  output      logic        out_range_error,

  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata
);

  // Configuration registers.
  logic [16:0] zone_r, zone_nxt;
  logic        dst_en_r, dst_en_nxt;

  // Flags that ride along with the item in flight.
  logic        dst_r, dst_nxt;
  logic        err_r, err_nxt;

  // Output register.
  logic            out_valid_r, out_valid_nxt;
  epcal_pkg::cal_t out_cal_r, out_cal_nxt;
  logic            out_dst_r, out_dst_nxt;
  logic            out_err_r, out_err_nxt;

  logic                       start;
  logic                       seq_idle;
  logic                       seq_done;
  logic                       load;
  epcal_pkg::cal_t            seq_res;
  logic [33:0]                adj;
  logic                       adj_neg;
  logic [epcal_pkg::AccW-1:0] adj_clamped;

  // Configuration writes. Only two registers exist, so every index names one of them.
  always_comb begin
    zone_nxt   = zone_r;
    dst_en_nxt = dst_en_r;
    if (cfg_we) begin
      unique case (cfg_index[0])
        epcal_pkg::CfgZoneOffset: zone_nxt   = cfg_wdata;
        epcal_pkg::CfgDaylight:   dst_en_nxt = cfg_wdata[0];
        default:                  zone_nxt   = zone_r;
      endcase
    end
  end

  // Local seconds: input minus the westward offset, plus an hour under daylight time.
  // The 34-bit two's complement sum cannot overflow, so bit 33 is the sign.
  assign adj = {2'b00, in_epoch_seconds}
             - {{17{zone_r[16]}}, zone_r}
             + (dst_en_r ? {18'd0, epcal_pkg::DstSecs} : 34'd0);
  assign adj_neg     = adj[33];
  assign adj_clamped = adj_neg ? '0 : adj[epcal_pkg::AccW-1:0];

  assign in_ready = seq_idle;
  assign start    = in_valid && seq_idle;

  // A finished result moves into the output register when that register is free or
  // being emptied in the same cycle.
  assign load = seq_done && (!out_valid_r || out_ready);

  always_comb begin
    dst_nxt = dst_r;
    err_nxt = err_r;
    if (start) begin
      dst_nxt = dst_en_r;
      err_nxt = adj_neg;
    end
  end

  always_comb begin
    out_cal_nxt = out_cal_r;
    out_dst_nxt = out_dst_r;
    out_err_nxt = out_err_r;
    if (load) begin
      out_cal_nxt = seq_res;
      out_dst_nxt = dst_r;
      out_err_nxt = err_r;
    end
    priority if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  epcal_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start),
    .adj_i   (adj_clamped),
    .take_i  (load),
    .idle_o  (seq_idle),
    .done_o  (seq_done),
    .res_o   (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r      <= '0;
      dst_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      zone_r      <= zone_nxt;
      dst_en_r    <= dst_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r     <= dst_nxt;
    err_r     <= err_nxt;
    out_cal_r <= out_cal_nxt;
    out_dst_r <= out_dst_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_year          = out_cal_r.year;
  assign out_month         = out_cal_r.month;
  assign out_day_of_month  = out_cal_r.day_of_month;
  assign out_hour          = out_cal_r.hour;
  assign out_minute        = out_cal_r.minute;
  assign out_second        = out_cal_r.second;
  assign out_weekday       = out_cal_r.weekday;
  assign out_day_of_year   = out_cal_r.day_of_year;
  assign out_daylight_flag = out_dst_r;
  assign out_range_error   = out_err_r;

endmodule

`default_nettype wire
